// ===== hdl/ppp_pkg.sv =====
`default_nettype none
package ppp_pkg;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 48;
  localparam int AxisW    = 48;
  localparam int CompW    = 16;
  localparam int AxisFrac = 14;
  localparam int StatusW  = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TARGET_X = 3'd0,
    REG_TARGET_Y = 3'd1,
    REG_TARGET_Z = 3'd2,
    REG_SEA_AXIS = 3'd3,
    REG_SKY_AXIS = 3'd4,
    REG_EYE_AXIS = 3'd5,
    REG_INV_DIST = 3'd6
  } cfg_reg_t;

  localparam logic [StatusW-1:0] ST_OK  = 2'd0;
  localparam logic [StatusW-1:0] ST_ZERO = 2'd1;
  localparam logic [StatusW-1:0] ST_SAT = 2'd2;

  localparam logic [AxisW-1:0] SEA_RESET = 48'h0000_0000_4000;
  localparam logic [AxisW-1:0] SKY_RESET = 48'h0000_4000_0000;
  localparam logic [AxisW-1:0] EYE_RESET = 48'h4000_0000_0000;
endpackage
`default_nettype wire

// ===== hdl/ppp_if.sv =====
`default_nettype none
interface ppp_in_if #(parameter int CW = 32);
  logic valid;
  logic ready;
  logic signed [CW-1:0] point_x;
  logic signed [CW-1:0] point_y;
  logic signed [CW-1:0] point_z;
  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

interface ppp_out_if #(parameter int CW = 32);
  logic valid;
  logic ready;
  logic signed [CW-1:0] screen_u;
  logic signed [CW-1:0] screen_v;
  logic [1:0] proj_status;
  modport source (output valid, screen_u, screen_v, proj_status, input ready);
  modport sink (input valid, screen_u, screen_v, proj_status, output ready);
endinterface

interface ppp_cfg_if;
  logic valid;
  logic ready;
  logic [2:0] index;
  logic [47:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/perspective_point_projection.sv =====
`default_nettype none
// Channel   Role    Payload
// pt_in     sink    point_x, point_y, point_z
// pt_out    source  screen_u, screen_v, proj_status
// cfg       sink    index, data
// One point is accepted every cycle unless the output stalls; the pipeline is 3 front
// stages, one cell per quotient bit (CW + FB + 4 cells) and one output stage.
// The whole pipeline advances together whenever the output register is empty
// or being taken, so a stall on the output holds every stage.
// Reset (synchronous) clears valid flags and loads the register defaults.
module perspective_point_projection #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  ppp_in_if.sink    pt_in,
  ppp_out_if.source pt_out,
  ppp_cfg_if.sink   cfg
);
  import ppp_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int FB = FRAC_BITS;
  localparam int UW = CW + 4;
  localparam int DW = UW + CW - FB + 2;
  localparam int NW = UW + FB;
  localparam int SW = 3;

  logic signed [CW-1:0] tx, ty, tz;
  logic [47:0]          sea, sky, eye;
  logic [CW-1:0]        kdist;
  logic                 en;
  logic                 f_vld, f_neg;
  logic signed [UW-1:0] f_u1, f_u2;
  logic [DW-1:0]        f_den;

  logic          c_vld [NW+1];
  logic [DW:0]   c_r1 [NW+1], c_r2 [NW+1];
  logic [NW-1:0] c_n1 [NW+1], c_n2 [NW+1], c_q1 [NW+1], c_q2 [NW+1];
  logic [DW-1:0] c_d [NW+1];
  logic [SW-1:0] c_s [NW+1];

  logic [NW-1:0]        q1, q2;
  logic                 neg1, neg2, sat1, sat2;
  logic [NW-1:0]        lim1, lim2;
  logic signed [CW-1:0] res1, res2;

  assign en       = !pt_out.valid || pt_out.ready;
  assign pt_in.ready = en;
  assign cfg.ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      tx <= '0; ty <= '0; tz <= '0;
      sea <= SEA_RESET; sky <= SKY_RESET; eye <= EYE_RESET;
      kdist <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_TARGET_X: tx <= CW'(cfg.data[31:0]);
        REG_TARGET_Y: ty <= CW'(cfg.data[31:0]);
        REG_TARGET_Z: tz <= CW'(cfg.data[31:0]);
        REG_SEA_AXIS: sea <= cfg.data;
        REG_SKY_AXIS: sky <= cfg.data;
        REG_EYE_AXIS: eye <= cfg.data;
        REG_INV_DIST: kdist <= CW'(cfg.data[31:0]);
        default: ;
      endcase
    end
  end

  ppp_front #(.CW(CW), .FB(FB), .UW(UW), .DW(DW)) u_front (
    .clk(clk), .rst(rst), .en(en), .in_vld(pt_in.valid && en),
    .px(pt_in.point_x), .py(pt_in.point_y), .pz(pt_in.point_z),
    .tx(tx), .ty(ty), .tz(tz), .sea(sea), .sky(sky), .eye(eye), .kdist(kdist),
    .out_vld(f_vld), .u1(f_u1), .u2(f_u2), .den_mag(f_den), .den_neg(f_neg)
  );

  // Load the head of the divider row with magnitudes and sign and zero-divisor side bits.
  assign c_vld[0] = f_vld;
  assign c_r1[0]  = '0;
  assign c_r2[0]  = '0;
  assign c_n1[0]  = NW'(f_u1[UW-1] ? UW'(-f_u1) : UW'(f_u1)) << FB;
  assign c_n2[0]  = NW'(f_u2[UW-1] ? UW'(-f_u2) : UW'(f_u2)) << FB;
  assign c_q1[0]  = '0;
  assign c_q2[0]  = '0;
  assign c_d[0]   = f_den;
  assign c_s[0]   = {f_den == '0, f_u1[UW-1] ^ f_neg, f_u2[UW-1] ^ f_neg};

  for (genvar g = 0; g < NW; g++) begin : g_cell
    ppp_div_cell #(.NW(NW), .DW(DW), .SW(SW)) u_cell (
      .clk(clk), .rst(rst), .en(en), .in_vld(c_vld[g]),
      .in_r1(c_r1[g]), .in_r2(c_r2[g]), .in_n1(c_n1[g]), .in_n2(c_n2[g]),
      .in_q1(c_q1[g]), .in_q2(c_q2[g]), .in_d(c_d[g]), .in_side(c_s[g]),
      .out_vld(c_vld[g+1]), .out_r1(c_r1[g+1]), .out_r2(c_r2[g+1]),
      .out_n1(c_n1[g+1]), .out_n2(c_n2[g+1]), .out_q1(c_q1[g+1]),
      .out_q2(c_q2[g+1]), .out_d(c_d[g+1]), .out_side(c_s[g+1])
    );
  end

  // Sign, saturation and status on the quotients.
  always_comb begin
    q1   = c_q1[NW];
    q2   = c_q2[NW];
    neg1 = c_s[NW][1];
    neg2 = c_s[NW][0];
    lim1 = (NW'(1) << (CW-1)) - NW'(!neg1);
    lim2 = (NW'(1) << (CW-1)) - NW'(!neg2);
    sat1 = q1 > lim1;
    sat2 = q2 > lim2;
    res1 = CW'(sat1 ? lim1 : q1);
    res2 = CW'(sat2 ? lim2 : q2);
    if (neg1) res1 = -res1;
    if (neg2) res2 = -res2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pt_out.valid <= 1'b0;
    end else if (en) begin
      pt_out.valid <= c_vld[NW];
    end
    if (en) begin
      if (c_s[NW][2]) begin
        pt_out.screen_u    <= '0;
        pt_out.screen_v    <= '0;
        pt_out.proj_status <= ST_ZERO;
      end else begin
        pt_out.screen_u    <= res1;
        pt_out.screen_v    <= res2;
        pt_out.proj_status <= (sat1 || sat2) ? ST_SAT : ST_OK;
      end
    end
  end

  // A held result must not change while the sink stalls.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    pt_out.valid && !pt_out.ready |=> $stable(pt_out.screen_u))
    else $error("output changed during stall");
  a_stat: assert property (@(posedge clk) disable iff (rst)
    pt_out.valid |-> pt_out.proj_status != 2'd3)
    else $error("bad status");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    pt_out.valid && pt_out.proj_status == ST_ZERO |-> pt_out.screen_u == '0)
    else $error("zero denominator gave nonzero output");
endmodule
`default_nettype wire

// ===== hdl/ppp_div_cell.sv =====
`default_nettype none
// One restoring division step for two numerators sharing a divisor.
// Each cell registers its outputs, so the row of cells forms a pipeline.
module ppp_div_cell #(
  parameter int NW = 64,
  parameter int DW = 64,
  parameter int SW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_vld,
  input  wire logic [DW:0]   in_r1,
  input  wire logic [DW:0]   in_r2,
  input  wire logic [NW-1:0] in_n1,
  input  wire logic [NW-1:0] in_n2,
  input  wire logic [NW-1:0] in_q1,
  input  wire logic [NW-1:0] in_q2,
  input  wire logic [DW-1:0] in_d,
  input  wire logic [SW-1:0] in_side,
  output logic               out_vld,
  output logic [DW:0]        out_r1,
  output logic [DW:0]        out_r2,
  output logic [NW-1:0]      out_n1,
  output logic [NW-1:0]      out_n2,
  output logic [NW-1:0]      out_q1,
  output logic [NW-1:0]      out_q2,
  output logic [DW-1:0]      out_d,
  output logic [SW-1:0]      out_side
);
  logic [DW+1:0] t1, t2;
  logic          g1, g2;

  // Shift in the next numerator bit and try the subtraction.
  always_comb begin
    t1 = {in_r1, in_n1[NW-1]};
    t2 = {in_r2, in_n2[NW-1]};
    g1 = t1 >= {2'b00, in_d};
    g2 = t2 >= {2'b00, in_d};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
    if (en) begin
      out_r1   <= g1 ? (DW+1)'(t1 - {2'b00, in_d}) : (DW+1)'(t1);
      out_r2   <= g2 ? (DW+1)'(t2 - {2'b00, in_d}) : (DW+1)'(t2);
      out_n1   <= {in_n1[NW-2:0], 1'b0};
      out_n2   <= {in_n2[NW-2:0], 1'b0};
      out_q1   <= {in_q1[NW-2:0], g1};
      out_q2   <= {in_q2[NW-2:0], g2};
      out_d    <= in_d;
      out_side <= in_side;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/ppp_front.sv =====
`default_nettype none
// Front end: target subtraction, dot products and denominator, three stages.
module ppp_front #(
  parameter int CW = 32,
  parameter int FB = 16,
  parameter int UW = CW + 4,
  parameter int DW = UW + CW - FB + 2
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 in_vld,
  input  wire logic signed [CW-1:0] px,
  input  wire logic signed [CW-1:0] py,
  input  wire logic signed [CW-1:0] pz,
  input  wire logic signed [CW-1:0] tx,
  input  wire logic signed [CW-1:0] ty,
  input  wire logic signed [CW-1:0] tz,
  input  wire logic [47:0]          sea,
  input  wire logic [47:0]          sky,
  input  wire logic [47:0]          eye,
  input  wire logic [CW-1:0]        kdist,
  output logic                      out_vld,
  output logic signed [UW-1:0]      u1,
  output logic signed [UW-1:0]      u2,
  output logic [DW-1:0]             den_mag,
  output logic                      den_neg
);
  localparam int DIFW = CW + 1;
  localparam int PW   = DIFW + 16;
  localparam int SW   = PW + 2;
  localparam int MW   = CW + UW;

  logic                   v1, v2;
  logic signed [DIFW-1:0] d [3];
  logic signed [PW-1:0]   pr [3][3];
  logic signed [SW-1:0]   sm [3];
  logic signed [UW-1:0]   s2u1, s2u2, s2u3;
  logic [UW-1:0]          mag3;
  logic [MW-1:0]          prod;
  logic [MW-1:0]          t;
  logic [DW-1:0]          one;

  assign one = DW'(1) << FB;

  // Stage 1: differences and the nine component products.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pr[0][i] <= d[i] * $signed(sea[16*i +: 16]);
        pr[1][i] <= d[i] * $signed(sky[16*i +: 16]);
        pr[2][i] <= d[i] * $signed(eye[16*i +: 16]);
      end
    end
  end

  always_comb begin
    d[0] = DIFW'(px) - DIFW'(tx);
    d[1] = DIFW'(py) - DIFW'(ty);
    d[2] = DIFW'(pz) - DIFW'(tz);
    for (int j = 0; j < 3; j++) begin
      sm[j] = SW'(pr[j][0]) + SW'(pr[j][1]) + SW'(pr[j][2]);
    end
  end

  // Stage 2: sums shifted down by the axis fraction, floor rounding.
  always_ff @(posedge clk) begin
    if (en) begin
      s2u1 <= UW'(sm[0] >>> 14);
      s2u2 <= UW'(sm[1] >>> 14);
      s2u3 <= UW'(sm[2] >>> 14);
    end
  end

  always_comb begin
    mag3 = s2u3[UW-1] ? UW'(-s2u3) : UW'(s2u3);
    prod = MW'(kdist) * MW'(mag3);
    t    = s2u3[UW-1] ? (prod + MW'((64'd1 << FB) - 1)) >> FB : prod >> FB;
  end

  // Stage 3: denominator magnitude and sign.
  always_ff @(posedge clk) begin
    if (en) begin
      u1 <= s2u1;
      u2 <= s2u2;
      if (!s2u3[UW-1]) begin
        den_mag <= DW'(t) + one;
        den_neg <= 1'b0;
      end else if (DW'(t) <= one) begin
        den_mag <= one - DW'(t);
        den_neg <= 1'b0;
      end else begin
        den_mag <= DW'(t) - one;
        den_neg <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      v1 <= in_vld;
      v2 <= v1;
      out_vld <= v2;
    end
  end
endmodule
`default_nettype wire
